FILE: hdl/linear_move_duration_executor_defines.svh
// ----------------------------------------------------------------------------
// Linear move duration executor assertion macros
// Shared property forms for the concurrent checks of the executor.
// ----------------------------------------------------------------------------
`ifndef LINEAR_MOVE_DURATION_EXECUTOR_DEFINES_SVH
`define LINEAR_MOVE_DURATION_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LMDE_ASSERT_IMPL(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LMDE_ASSERT_NEXT(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lmde_pkg.sv
// ----------------------------------------------------------------------------
// Linear move duration executor package
// Command and status types between controller and datapath, field codes
// and register defaults.
// ----------------------------------------------------------------------------
package lmde_pkg;

  localparam int FEED_WIDTH      = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int TYPE_WIDTH      = 3;
  localparam int GRIP_WIDTH      = 2;
  localparam int DUR_WIDTH       = 28;

  localparam logic [DUR_WIDTH-1:0] DUR_MAX = {DUR_WIDTH{1'b1}};

  // 3600 = 4096 - 512 + 16
  localparam int SCALE_SH_HI  = 12;
  localparam int SCALE_SH_MID = 9;
  localparam int SCALE_SH_LO  = 4;

  localparam logic [TYPE_WIDTH-1:0] REQ_RAPID      = 3'd0;
  localparam logic [TYPE_WIDTH-1:0] REQ_LINEAR     = 3'd1;
  localparam logic [TYPE_WIDTH-1:0] REQ_GRIP_OPEN  = 3'd2;
  localparam logic [TYPE_WIDTH-1:0] REQ_GRIP_CLOSE = 3'd3;
  localparam logic [TYPE_WIDTH-1:0] REQ_SET_POS    = 3'd4;

  localparam logic [GRIP_WIDTH-1:0] GRIP_NONE  = 2'd0;
  localparam logic [GRIP_WIDTH-1:0] GRIP_OPEN  = 2'd1;
  localparam logic [GRIP_WIDTH-1:0] GRIP_CLOSE = 2'd2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT_FEED = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_FEED     = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_MOVE     = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_DURATION = 2'd3;

  localparam logic [CFG_WIDTH-1:0] RST_DEFAULT_FEED = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] RST_MAX_FEED     = 16'd10000;
  localparam logic [CFG_WIDTH-1:0] RST_MIN_MOVE     = 16'd10;
  localparam logic [CFG_WIDTH-1:0] RST_MIN_DURATION = 16'd1;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SQUARE,
    OP_SCALE,
    OP_ROOT,
    OP_DIVIDE,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic moving;
  } dp_stat_t;

endpackage

FILE: hdl/linear_move_duration_executor.sv
// Move item: after the accepting edge, 4 squaring, 3 scaling, then one root
// bit and one quotient bit per cycle, POS_WIDTH+7 each, before m_tvalid
// rises. Other commands go straight to the result.
// A new item is taken only after the result is registered and the
// controller is back in idle. Reset: synchronous; position to zero,
// feedrate and config registers to their defaults.
// ----------------------------------------------------------------------------
// Linear move duration executor
// Executes motion, gripper and set-position commands and computes the
// duration of each line move from the travelled distance and feedrate.
// ----------------------------------------------------------------------------
module linear_move_duration_executor #(
  parameter int POS_WIDTH = 21
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // has_x, x, has_y, y, has_z, z, has_f, f
  input  logic [((3*POS_WIDTH+20+7)/8)*8-1:0]  s_tdata,
  // req_type
  input  logic [lmde_pkg::TYPE_WIDTH-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // status, move_valid, pos_x, pos_y, pos_z, duration_ms, gripper_cmd
  output logic [((3*POS_WIDTH+32+7)/8)*8-1:0]  m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lmde_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lmde_pkg::CFG_WIDTH-1:0]       cfg_data
);

  localparam int P     = POS_WIDTH;
  localparam int OW    = ((3*P+32+7)/8)*8;
  localparam int X_LSB = 1;
  localparam int HY    = 1 + P;
  localparam int Y_LSB = 2 + P;
  localparam int HZ    = 2 + 2*P;
  localparam int Z_LSB = 3 + 2*P;
  localparam int HF    = 3 + 3*P;
  localparam int F_LSB = 4 + 3*P;

  lmde_pkg::dp_cmd_t  cmd;
  lmde_pkg::dp_stat_t stat;

  logic                                status;
  logic                                move_valid;
  logic signed [P-1:0]                 pos_x;
  logic signed [P-1:0]                 pos_y;
  logic signed [P-1:0]                 pos_z;
  logic [lmde_pkg::DUR_WIDTH-1:0]      duration_ms;
  logic [lmde_pkg::GRIP_WIDTH-1:0]     gripper_cmd;

  assign cfg_ready = 1'b1;

  assign m_tdata = OW'({gripper_cmd, duration_ms, pos_z, pos_y, pos_x, move_valid, status});

  lmde_controller #(
    .POS_WIDTH(POS_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmde_datapath #(
    .POS_WIDTH(POS_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (s_tuser),
    .has_x       (s_tdata[0]),
    .x           (s_tdata[X_LSB +: P]),
    .has_y       (s_tdata[HY]),
    .y           (s_tdata[Y_LSB +: P]),
    .has_z       (s_tdata[HZ]),
    .z           (s_tdata[Z_LSB +: P]),
    .has_f       (s_tdata[HF]),
    .f           (s_tdata[F_LSB +: lmde_pkg::FEED_WIDTH]),
    .status      (status),
    .move_valid  (move_valid),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .duration_ms (duration_ms),
    .gripper_cmd (gripper_cmd)
  );

endmodule

FILE: hdl/lmde_datapath.sv
// ----------------------------------------------------------------------------
// Linear move duration executor datapath
// Planned position, feedrate and config registers, squared distance,
// shift-subtract square root and restoring divide.
// ----------------------------------------------------------------------------
module lmde_datapath #(
  parameter int POS_WIDTH = 21
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lmde_pkg::dp_cmd_t                     cmd,
  output lmde_pkg::dp_stat_t                    stat,
  input  logic                                  cfg_wr,
  input  logic [lmde_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [lmde_pkg::CFG_WIDTH-1:0]        cfg_data,
  input  logic [lmde_pkg::TYPE_WIDTH-1:0]       req_type,
  input  logic                                  has_x,
  input  logic signed [POS_WIDTH-1:0]           x,
  input  logic                                  has_y,
  input  logic signed [POS_WIDTH-1:0]           y,
  input  logic                                  has_z,
  input  logic signed [POS_WIDTH-1:0]           z,
  input  logic                                  has_f,
  input  logic [lmde_pkg::FEED_WIDTH-1:0]       f,
  output logic                                  status,
  output logic                                  move_valid,
  output logic signed [POS_WIDTH-1:0]           pos_x,
  output logic signed [POS_WIDTH-1:0]           pos_y,
  output logic signed [POS_WIDTH-1:0]           pos_z,
  output logic [lmde_pkg::DUR_WIDTH-1:0]        duration_ms,
  output logic [lmde_pkg::GRIP_WIDTH-1:0]       gripper_cmd
);

  localparam int P  = POS_WIDTH;
  localparam int RW = P + 7;
  localparam int SW = 2 * P + 2;
  localparam int TW = 2 * RW;
  localparam int XW = (RW > lmde_pkg::DUR_WIDTH) ? RW : lmde_pkg::DUR_WIDTH;
  localparam int FW = lmde_pkg::FEED_WIDTH;

  function automatic logic [P-1:0] abs_diff(input logic [P-1:0] a, input logic [P-1:0] b);
    logic [P:0] d;
    logic [P:0] n;
    d = {a[P-1], a} - {b[P-1], b};
    n = (P+1)'(0) - d;
    return d[P] ? n[P-1:0] : d[P-1:0];
  endfunction

  logic [FW-1:0] default_feed;
  logic [FW-1:0] max_feed;
  logic [FW-1:0] min_move;
  logic [FW-1:0] min_dur;

  logic signed [P-1:0] planned_x;
  logic signed [P-1:0] planned_y;
  logic signed [P-1:0] planned_z;
  logic [FW-1:0]       feed;

  logic [P-1:0]      mag_x;
  logic [P-1:0]      mag_y;
  logic [P-1:0]      mag_z;
  logic              moving;
  logic              res_status;
  logic [lmde_pkg::GRIP_WIDTH-1:0] res_grip;
  logic              zero_len;

  logic [2*P-1:0] prod;
  logic [SW-1:0]  sum_sq;
  logic [TW-1:0]  scaled;
  logic [RW+1:0]  sq_rem;
  logic [RW-1:0]  root;
  logic [FW-1:0]  div_rem;

  logic              is_move;
  logic              reject;
  logic signed [P-1:0] tgt_x;
  logic signed [P-1:0] tgt_y;
  logic signed [P-1:0] tgt_z;
  logic [P-1:0]      mul_a;
  logic [2*P-1:0]    mul_p;
  logic [RW+1:0]     rsh;
  logic [RW+1:0]     trial;
  logic              r_ge;
  logic [FW:0]       dsh;
  logic [FW:0]       dsub;
  logic              d_ge;
  logic [XW-1:0]     q_ext;
  logic [lmde_pkg::DUR_WIDTH-1:0] dur;

  assign is_move = (req_type == lmde_pkg::REQ_RAPID) || (req_type == lmde_pkg::REQ_LINEAR);
  assign reject  = has_f && (f > max_feed);
  assign tgt_x   = has_x ? x : planned_x;
  assign tgt_y   = has_y ? y : planned_y;
  assign tgt_z   = has_z ? z : planned_z;

  always_comb begin
    case (cmd.sel)
      2'd0:    mul_a = mag_x;
      2'd1:    mul_a = mag_y;
      2'd2:    mul_a = mag_z;
      default: mul_a = P'(min_move);
    endcase
  end

  assign mul_p = mul_a * mul_a;

  assign rsh   = {sq_rem[RW-1:0], scaled[TW-1:TW-2]};
  assign trial = {root, 2'b01};
  assign r_ge  = rsh >= trial;

  assign dsh  = {div_rem, root[RW-1]};
  assign dsub = dsh - {1'b0, feed};
  assign d_ge = dsh >= {1'b0, feed};

  assign q_ext = XW'(root);

  always_comb begin
    if (!moving || zero_len) begin
      dur = '0;
    end else if (feed == '0) begin
      dur = lmde_pkg::DUR_MAX;
    end else if (q_ext > XW'(lmde_pkg::DUR_MAX)) begin
      dur = lmde_pkg::DUR_MAX;
    end else if (q_ext == '0) begin
      dur = lmde_pkg::DUR_WIDTH'(min_dur);
    end else begin
      dur = q_ext[lmde_pkg::DUR_WIDTH-1:0];
    end
  end

  assign stat.moving = moving;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_feed <= lmde_pkg::RST_DEFAULT_FEED;
      max_feed     <= lmde_pkg::RST_MAX_FEED;
      min_move     <= lmde_pkg::RST_MIN_MOVE;
      min_dur      <= lmde_pkg::RST_MIN_DURATION;
    end else if (cfg_wr) begin
      case (cfg_index)
        lmde_pkg::CFG_DEFAULT_FEED: default_feed <= cfg_data;
        lmde_pkg::CFG_MAX_FEED:     max_feed     <= cfg_data;
        lmde_pkg::CFG_MIN_MOVE:     min_move     <= cfg_data;
        lmde_pkg::CFG_MIN_DURATION: min_dur      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      planned_x <= '0;
      planned_y <= '0;
      planned_z <= '0;
      feed      <= lmde_pkg::RST_DEFAULT_FEED;
      moving    <= 1'b0;
    end else if (cmd.op == lmde_pkg::OP_LOAD) begin
      moving <= is_move && !reject;
      if (is_move && !reject) begin
        planned_x <= tgt_x;
        planned_y <= tgt_y;
        planned_z <= tgt_z;
        if (has_f && (f != '0)) begin
          feed <= f;
        end
      end else if (req_type == lmde_pkg::REQ_SET_POS) begin
        planned_x <= x;
        planned_y <= y;
        planned_z <= z;
        feed      <= default_feed;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lmde_pkg::OP_LOAD: begin
        mag_x      <= abs_diff(tgt_x, planned_x);
        mag_y      <= abs_diff(tgt_y, planned_y);
        mag_z      <= abs_diff(tgt_z, planned_z);
        res_status <= (is_move && reject) || (req_type > lmde_pkg::REQ_SET_POS);
        if (req_type == lmde_pkg::REQ_GRIP_OPEN) begin
          res_grip <= lmde_pkg::GRIP_OPEN;
        end else if (req_type == lmde_pkg::REQ_GRIP_CLOSE) begin
          res_grip <= lmde_pkg::GRIP_CLOSE;
        end else begin
          res_grip <= lmde_pkg::GRIP_NONE;
        end
      end
      lmde_pkg::OP_SQUARE: begin
        prod <= mul_p;
        if (cmd.sel == 2'd0) begin
          sum_sq <= '0;
        end else begin
          sum_sq <= sum_sq + SW'(prod);
        end
      end
      lmde_pkg::OP_SCALE: begin
        case (cmd.sel)
          2'd0: begin
            scaled   <= TW'(sum_sq) << lmde_pkg::SCALE_SH_HI;
            zero_len <= sum_sq <= SW'(prod);
          end
          2'd1: scaled <= scaled - (TW'(sum_sq) << lmde_pkg::SCALE_SH_MID);
          2'd2: begin
            scaled  <= scaled + (TW'(sum_sq) << lmde_pkg::SCALE_SH_LO);
            sq_rem  <= '0;
            root    <= '0;
            div_rem <= '0;
          end
          default: ;
        endcase
      end
      lmde_pkg::OP_ROOT: begin
        scaled <= scaled << 2;
        sq_rem <= r_ge ? (rsh - trial) : rsh;
        root   <= {root[RW-2:0], r_ge};
      end
      lmde_pkg::OP_DIVIDE: begin
        div_rem <= d_ge ? dsub[FW-1:0] : dsh[FW-1:0];
        root    <= {root[RW-2:0], d_ge};
      end
      lmde_pkg::OP_FINISH: begin
        status      <= res_status;
        move_valid  <= moving;
        pos_x       <= planned_x;
        pos_y       <= planned_y;
        pos_z       <= planned_z;
        duration_ms <= dur;
        gripper_cmd <= res_grip;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/lmde_controller.sv
// ----------------------------------------------------------------------------
// Linear move duration executor controller
// Sequences load, squaring, scaling, root and divide steps, and owns the
// stream handshakes.
// ----------------------------------------------------------------------------
`include "linear_move_duration_executor_defines.svh"

module lmde_controller #(
  parameter int POS_WIDTH = 21
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  lmde_pkg::dp_stat_t stat,
  output lmde_pkg::dp_cmd_t  cmd
);

  localparam int RW = POS_WIDTH + 7;
  localparam int CW = $clog2(RW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_SCALE,
    ST_ROOT,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          out_free;
  logic          in_idle;
  logic          in_finish;
  logic          finish_go;
  logic          iterating;

  assign out_free  = !m_tvalid || m_tready;
  assign in_idle   = (state == ST_IDLE);
  assign in_finish = (state == ST_FINISH);
  assign finish_go = in_finish && out_free;
  assign iterating = (state == ST_ROOT) || (state == ST_DIVIDE);

  always_comb begin
    cmd.op  = lmde_pkg::OP_IDLE;
    cmd.sel = cnt[1:0];
    case (state)
      ST_IDLE:   if (s_tvalid && s_tready) cmd.op = lmde_pkg::OP_LOAD;
      ST_SQUARE: cmd.op = lmde_pkg::OP_SQUARE;
      ST_SCALE:  cmd.op = lmde_pkg::OP_SCALE;
      ST_ROOT:   cmd.op = lmde_pkg::OP_ROOT;
      ST_DIVIDE: cmd.op = lmde_pkg::OP_DIVIDE;
      ST_FINISH: if (out_free) cmd.op = lmde_pkg::OP_FINISH;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !in_finish) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            s_tready <= 1'b0;
            state    <= ST_CHECK;
          end else begin
            s_tready <= 1'b1;
          end
        end
        ST_CHECK: begin
          cnt   <= '0;
          state <= stat.moving ? ST_SQUARE : ST_FINISH;
        end
        ST_SQUARE: begin
          if (cnt == CW'(3)) begin
            cnt   <= '0;
            state <= ST_SCALE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SCALE: begin
          if (cnt == CW'(2)) begin
            cnt   <= '0;
            state <= ST_ROOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROOT: begin
          if (cnt == CW'(RW - 1)) begin
            cnt   <= '0;
            state <= ST_DIVIDE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIVIDE: begin
          if (cnt == CW'(RW - 1)) begin
            cnt   <= '0;
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LMDE_ASSERT_IMPL(a_busy_not_ready, clk, rst, !in_idle, !s_tready, "ready while busy")
  `LMDE_ASSERT_IMPL(a_cnt_range, clk, rst, iterating, cnt < CW'(RW), "step count overrun")
  `LMDE_ASSERT_NEXT(a_finish_issues, clk, rst, finish_go, m_tvalid && in_idle, "result not issued")
  `LMDE_ASSERT_IMPL(a_valid_from_finish, clk, rst, $rose(m_tvalid), $past(in_finish), "no finish")

endmodule
